[rtl/dpa_pkg.sv]
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared widths, register indexes, command codes and the descent profile
// table of the descent profile autopilot.
// ----------------------------------------------------------------------------
`default_nettype none

package dpa_pkg;

  // field widths
  localparam int ALT_W   = 22;
  localparam int SPD_W   = 18;
  localparam int PWR_W   = 11;
  localparam int CMD_W   = 2;
  localparam int SLOPE_W = 24;   // Q0.24 slope magnitude, max value below 2^24
  localparam int FRAC_W  = 24;
  localparam int PROD_W  = ALT_W + SLOPE_W;
  localparam int CFG_W   = 22;   // widest register
  localparam int CFG_IDX_W = 2;

  // profile table
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = 4;
  localparam int DPA_BREAKPOINTS = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_LIMIT = 2'd3;

  // register reset values
  localparam logic [PWR_W-1:0] CRUISE_LIMIT_RST  = 11'd911;
  localparam logic [ALT_W-1:0] LOW_THRESHOLD_RST = 22'd10000;
  localparam logic [PWR_W-1:0] LANDING_LIMIT_RST = 11'd1024;

  // motor commands
  localparam logic [CMD_W-1:0] CMD_HOLD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAISE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOWER = 2'd2;

  // breakpoint altitude, mm
  function automatic logic [ALT_W-1:0] bp_alt(input logic [IDX_W-1:0] idx);
    unique case (idx)
      4'd0:    bp_alt = 22'd1000000;
      4'd1:    bp_alt = 22'd450000;
      4'd2:    bp_alt = 22'd270000;
      4'd3:    bp_alt = 22'd200000;
      4'd4:    bp_alt = 22'd100000;
      4'd5:    bp_alt = 22'd25000;
      4'd6:    bp_alt = 22'd400;
      default: bp_alt = '0;
    endcase
  endfunction

  // breakpoint speed, mm/s
  function automatic logic signed [SPD_W-1:0] bp_speed(input logic [IDX_W-1:0] idx);
    unique case (idx)
      4'd0:    bp_speed = -18'sd35000;
      4'd1:    bp_speed = -18'sd30000;
      4'd2:    bp_speed = -18'sd23000;
      4'd3:    bp_speed = -18'sd18000;
      4'd4:    bp_speed = -18'sd10000;
      4'd5:    bp_speed = -18'sd4000;
      4'd6:    bp_speed = -18'sd300;
      default: bp_speed = '0;
    endcase
  endfunction

  // slope magnitude of the segment ending at entry idx, speed per mm in Q0.24
  function automatic logic [SLOPE_W-1:0] bp_slope(input logic [IDX_W-1:0] idx);
    unique case (idx)
      4'd1:    bp_slope = 24'd152520;
      4'd2:    bp_slope = 24'd652447;
      4'd3:    bp_slope = 24'd1198373;
      4'd4:    bp_slope = 24'd1342177;
      4'd5:    bp_slope = 24'd1342177;
      4'd6:    bp_slope = 24'd2523402;
      4'd7:    bp_slope = 24'd12582912;
      default: bp_slope = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/descent_profile_autopilot.sv]
// ----------------------------------------------------------------------------
// descent_profile_autopilot
// Each sample (altitude, vertical speed, engine power) yields one result:
// the target vertical speed from a piecewise-linear descent profile and a
// raise / lower / hold power step command. Throughput is one transaction per
// clock while out_ready does not stall the output. An accepted sample passes
// four register stages: input compare, segment select, slope multiply, and
// round/saturate/decide, the last of which drives out_valid.
// The 22x24 slope multiply is the deepest stage. Back-pressure on out_ready
// stalls only the stages that are full, so bubbles get squeezed out.
// Configuration registers are meant to be written while no transaction is in
// flight; enable gates the command at the output stage and the power caps are
// applied at the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module descent_profile_autopilot
  import dpa_pkg::*;
#(
  parameter int BREAKPOINTS = DPA_BREAKPOINTS   // 2..16 table entries in use
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ALT_W-1:0]            in_altitude_mm,
  input  logic signed [SPD_W-1:0]     in_vertical_speed,
  input  logic [PWR_W-1:0]            in_current_power,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SPD_W-1:0]     out_target_speed,
  output logic [CMD_W-1:0]            out_motor_command,
  output logic                        out_engaged
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             enable_r;
  logic [PWR_W-1:0] cruise_limit_r;
  logic [ALT_W-1:0] low_thr_r;
  logic [PWR_W-1:0] landing_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r        <= 1'b0;
      cruise_limit_r  <= CRUISE_LIMIT_RST;
      low_thr_r       <= LOW_THRESHOLD_RST;
      landing_limit_r <= LANDING_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:        enable_r        <= cfg_data[0];
        REG_CRUISE_LIMIT:  cruise_limit_r  <= cfg_data[PWR_W-1:0];
        REG_LOW_THRESHOLD: low_thr_r       <= cfg_data[ALT_W-1:0];
        REG_LANDING_LIMIT: landing_limit_r <= cfg_data[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage advance: a stage loads when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv_out;

  assign adv_out  = !out_valid_r || out_ready;
  assign adv3     = !v3_r || adv_out;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)    v1_r        <= in_valid;
      if (adv2)    v2_r        <= v1_r;
      if (adv3)    v3_r        <= v2_r;
      if (adv_out) out_valid_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: parallel breakpoint compares and power cap check
  // --------------------------------------------------------------------------
  logic [TABLE_SLOTS-1:0]    s1_hit_nxt, s1_hit_r;
  logic                      s1_pwr_ok_nxt, s1_pwr_ok_r;
  logic [ALT_W-1:0]          s1_alt_r;
  logic signed [SPD_W-1:0]   s1_speed_r;
  logic [PWR_W-1:0]          cap;

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      s1_hit_nxt[i] = (i >= 1) && (i < BREAKPOINTS) &&
                      (bp_alt(IDX_W'(i)) < in_altitude_mm);
    end
  end

  // landing cap strictly below the threshold
  assign cap           = (in_altitude_mm < low_thr_r) ? landing_limit_r : cruise_limit_r;
  assign s1_pwr_ok_nxt = in_current_power < cap;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_hit_r    <= s1_hit_nxt;
      s1_pwr_ok_r <= s1_pwr_ok_nxt;
      s1_alt_r    <= in_altitude_mm;
      s1_speed_r  <= in_vertical_speed;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: first hit wins; fetch segment base, slope and altitude offset
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]          sel_idx;
  logic                      s2_found_nxt, s2_found_r;
  logic [ALT_W-1:0]          s2_diff_nxt, s2_diff_r;
  logic [SLOPE_W-1:0]        s2_slope_r;
  logic signed [SPD_W-1:0]   s2_base_r;
  logic signed [SPD_W-1:0]   s2_speed_r;
  logic                      s2_pwr_ok_r;

  always_comb begin
    sel_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 1; i--) begin
      if (s1_hit_r[i]) sel_idx = IDX_W'(i);
    end
  end

  assign s2_found_nxt = |s1_hit_r;
  assign s2_diff_nxt  = s1_alt_r - bp_alt(sel_idx);   // hit implies no underflow

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_found_r  <= s2_found_nxt;
      s2_diff_r   <= s2_diff_nxt;
      s2_slope_r  <= bp_slope(sel_idx);
      s2_base_r   <= bp_speed(sel_idx);
      s2_speed_r  <= s1_speed_r;
      s2_pwr_ok_r <= s1_pwr_ok_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: offset times slope
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]         s3_prod_nxt, s3_prod_r;
  logic                      s3_found_r;
  logic signed [SPD_W-1:0]   s3_base_r;
  logic signed [SPD_W-1:0]   s3_speed_r;
  logic                      s3_pwr_ok_r;

  assign s3_prod_nxt = PROD_W'(s2_diff_r) * PROD_W'(s2_slope_r);

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_prod_r   <= s3_prod_nxt;
      s3_found_r  <= s2_found_r;
      s3_base_r   <= s2_base_r;
      s3_speed_r  <= s2_speed_r;
      s3_pwr_ok_r <= s2_pwr_ok_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round half up, subtract, saturate to -131072..0, decide command
  // --------------------------------------------------------------------------
  localparam int MAG_W = PROD_W + 1 - FRAC_W;
  localparam int TGT_W = MAG_W + 2;

  logic [PROD_W:0]           prod_rnd;
  logic [MAG_W-1:0]          mag;
  logic signed [TGT_W-1:0]   tgt_wide;
  logic signed [TGT_W-1:0]   tgt_min;
  logic signed [SPD_W-1:0]   target_nxt, target_r;
  logic [CMD_W-1:0]          cmd_nxt, cmd_r;
  logic                      engaged_r;

  assign prod_rnd = {1'b0, s3_prod_r} + ((PROD_W + 1)'(1) << (FRAC_W - 1));
  assign mag      = prod_rnd[PROD_W:FRAC_W];
  assign tgt_wide = TGT_W'(s3_base_r) - $signed({2'b00, mag});
  assign tgt_min  = -(TGT_W'(1) <<< (SPD_W - 1));

  always_comb begin
    if (!s3_found_r) begin
      target_nxt = '0;
    end else if (tgt_wide < tgt_min) begin
      target_nxt = {1'b1, {(SPD_W-1){1'b0}}};
    end else if (tgt_wide > 0) begin
      target_nxt = '0;
    end else begin
      target_nxt = tgt_wide[SPD_W-1:0];
    end

    cmd_nxt = CMD_HOLD;
    if (enable_r) begin
      if (s3_speed_r < target_nxt) begin
        if (s3_pwr_ok_r) cmd_nxt = CMD_RAISE;
      end else begin
        cmd_nxt = CMD_LOWER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      target_r  <= target_nxt;
      cmd_r     <= cmd_nxt;
      engaged_r <= enable_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target_speed  = target_r;
  assign out_motor_command = cmd_r;
  assign out_engaged       = engaged_r;

`ifndef NO_ASSERTIONS
  // disengaged results always hold power
  a_hold_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_engaged |-> out_motor_command == CMD_HOLD)
    else $error("command issued while disengaged");

  // target never climbs
  a_target_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_speed[SPD_W-1] || out_target_speed == '0))
    else $error("positive target speed");

  // an accepted sample always occupies the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction lost at stage 1");

  // a full pipe never lets stage 3 overwrite a held result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && v3_r |=> out_valid_r && v3_r)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

[sim/descent_profile_autopilot_tb.sv]
// ----------------------------------------------------------------------------
// descent_profile_autopilot_tb
// Self-checking bench for the descent profile autopilot. A queue of sensor
// samples feeds a valid/ready driver. Every accepted sample is run through
// a local profile and command predictor. The monitor checks each result
// transaction field by field against the oldest prediction. Register
// settings change only while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module descent_profile_autopilot_tb;
  import dpa_pkg::*;

  localparam int PROFILE_N   = 8;      // breakpoints in the built-in profile
  localparam int SEG_ITEMS   = 300;    // random samples per register setting
  localparam int STALL_LIMIT = 5000;   // cycles with no transaction at all
  localparam longint ALT_MAX = (64'd1 << ALT_W) - 1;
  localparam longint PWR_MAX = (64'd1 << PWR_W) - 1;
  localparam longint SPD_MIN = -(64'sd1 <<< (SPD_W - 1));
  localparam longint SPD_MAX = (64'sd1 <<< (SPD_W - 1)) - 1;

  typedef struct packed {
    logic [ALT_W-1:0] alt;
    logic [SPD_W-1:0] spd;
    logic [PWR_W-1:0] pwr;
  } sample_t;

  typedef struct packed {
    logic [SPD_W-1:0] target;
    logic [CMD_W-1:0] cmd;
    logic             engaged;
  } result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_ENABLE;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ALT_W-1:0]        in_altitude_mm = '0;
  logic signed [SPD_W-1:0] in_vertical_speed = '0;
  logic [PWR_W-1:0]        in_current_power = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SPD_W-1:0] out_target_speed;
  logic [CMD_W-1:0]        out_motor_command;
  logic                    out_engaged;

  always #2 clk = ~clk;

  descent_profile_autopilot dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_altitude_mm    (in_altitude_mm),
    .in_vertical_speed (in_vertical_speed),
    .in_current_power  (in_current_power),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target_speed  (out_target_speed),
    .out_motor_command (out_motor_command),
    .out_engaged       (out_engaged)
  );

  // Local copy of the registers, as the DUT should hold them.
  logic             engage_reg  = 1'b0;
  logic [PWR_W-1:0] cruise_cap  = CRUISE_LIMIT_RST;
  logic [ALT_W-1:0] low_alt     = LOW_THRESHOLD_RST;
  logic [PWR_W-1:0] landing_cap = LANDING_LIMIT_RST;

  sample_t queued_samples[$];      // waiting for the driver
  result_t predicted_results[$];   // accepted, result not yet seen
  sample_t drive_item;
  result_t seen_item;
  int      send_gap_pct = 0;       // chance in 100 that the driver idles
  int      recv_gap_pct = 0;       // chance in 100 that out_ready drops
  int      errors = 0;
  int      stall_cycles = 0;

  // --------------------------------------------------------------------------
  // Descent profile: altitude in mm and target speed in mm/s per breakpoint,
  // highest altitude first. The last entry pins the ground at zero speed.
  // --------------------------------------------------------------------------
  function automatic longint profile_alt(int k);
    case (k)
      0:       return 1000000;
      1:       return 450000;
      2:       return 270000;
      3:       return 200000;
      4:       return 100000;
      5:       return 25000;
      6:       return 400;
      default: return 0;
    endcase
  endfunction

  function automatic longint profile_speed(int k);
    case (k)
      0:       return -35000;
      1:       return -30000;
      2:       return -23000;
      3:       return -18000;
      4:       return -10000;
      5:       return -4000;
      6:       return -300;
      default: return 0;
    endcase
  endfunction

  // Q0.24 magnitude of speed per mm on the segment that ends at entry k,
  // rounded to nearest.
  function automatic longint seg_slope(int k);
    longint ds;
    longint da;
    ds = profile_speed(k) - profile_speed(k - 1);
    da = profile_alt(k - 1) - profile_alt(k);
    return ((ds <<< FRAC_W) + da / 2) / da;
  endfunction

  // First breakpoint (from entry 1) strictly below the altitude anchors the
  // segment; above the top breakpoint the top segment just keeps going.
  // Nothing below (altitude zero) gives a target of zero.
  function automatic logic signed [SPD_W-1:0] profile_target(logic [ALT_W-1:0] alt);
    longint diff;
    longint mag;
    longint t;
    t = 0;
    for (int k = 1; k < PROFILE_N && k < DPA_BREAKPOINTS; k++) begin
      if (profile_alt(k) < longint'(alt)) begin
        diff = longint'(alt) - profile_alt(k);
        mag  = (diff * seg_slope(k) + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        t    = profile_speed(k) - mag;
        if (t < SPD_MIN) t = SPD_MIN;
        if (t > 0) t = 0;
        break;
      end
    end
    return t[SPD_W-1:0];
  endfunction

  function automatic result_t autopilot_result(sample_t s);
    result_t          r;
    logic [PWR_W-1:0] cap;
    r.target  = profile_target(s.alt);
    cap       = (s.alt < low_alt) ? landing_cap : cruise_cap;
    r.engaged = engage_reg;
    r.cmd     = CMD_HOLD;
    if (engage_reg) begin
      if ($signed(s.spd) < $signed(r.target)) begin
        if (s.pwr < cap) r.cmd = CMD_RAISE;
      end else begin
        r.cmd = CMD_LOWER;
      end
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Random sample, biased toward the interesting edges: breakpoints, the
  // threshold, speed equal to the target, power equal to the active cap.
  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    longint  v;
    longint  cap;
    pick = $urandom_range(99);
    if (pick < 25) begin
      v = profile_alt($urandom_range(PROFILE_N - 1)) + longint'($urandom_range(6)) - 3;
    end else if (pick < 40) begin
      v = longint'(low_alt) + longint'($urandom_range(6)) - 3;
    end else if (pick < 60) begin
      v = $urandom_range(2000);
    end else begin
      v = $urandom() & ALT_MAX;
    end
    s.alt = ALT_W'(clamp(v, 0, ALT_MAX));

    pick = $urandom_range(99);
    if (pick < 50) begin
      v = longint'($signed(profile_target(s.alt))) + longint'($urandom_range(6)) - 3;
    end else if (pick < 60) begin
      v = $urandom_range(1) ? SPD_MAX : SPD_MIN;
    end else begin
      v = longint'($signed(SPD_W'($urandom())));
    end
    s.spd = SPD_W'(clamp(v, SPD_MIN, SPD_MAX));

    cap  = (s.alt < low_alt) ? landing_cap : cruise_cap;
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = cap + longint'($urandom_range(4)) - 2;
    end else if (pick < 80) begin
      v = $urandom_range(1024);
    end else begin
      v = $urandom() & PWR_MAX;
    end
    s.pwr = PWR_W'(clamp(v, 0, PWR_MAX));
    return s;
  endfunction

  task automatic queue_sample(longint alt, longint spd, longint pwr);
    sample_t s;
    s.alt = alt[ALT_W-1:0];
    s.spd = spd[SPD_W-1:0];
    s.pwr = pwr[PWR_W-1:0];
    queued_samples.push_back(s);
  endtask

  function automatic longint target_of(longint alt);
    return longint'($signed(profile_target(alt[ALT_W-1:0])));
  endfunction

  task automatic note_mismatch(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Register write, one clock of cfg_we. Only used while nothing is in flight,
  // so the local copy can follow right away.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ENABLE:        engage_reg  = val[0];
      REG_CRUISE_LIMIT:  cruise_cap  = val[PWR_W-1:0];
      REG_LOW_THRESHOLD: low_alt     = val[ALT_W-1:0];
      REG_LANDING_LIMIT: landing_cap = val[PWR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned en, int unsigned cruise, int unsigned thr,
                               int unsigned landing);
    write_reg(REG_ENABLE, en);
    write_reg(REG_CRUISE_LIMIT, cruise);
    write_reg(REG_LOW_THRESHOLD, thr);
    write_reg(REG_LANDING_LIMIT, landing);
  endtask

  // Sender holds off until every queued sample has gone through and every
  // predicted result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_samples.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: a new sample goes out only once the current one is taken (or the
  // channel is empty); in_valid is assigned once per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (queued_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drive_item        = queued_samples.pop_front();
        in_valid          <= 1'b1;
        in_altitude_mm    <= drive_item.alt;
        in_vertical_speed <= drive_item.spd;
        in_current_power  <= drive_item.pwr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_gap_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: check the result transaction first, then record the prediction
  // for a sample taken at this edge. Latency keeps the two apart.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, target %0d command %0d engaged %0d",
                   $time, out_target_speed, out_motor_command, out_engaged);
        end else begin
          seen_item = predicted_results.pop_front();
          if (out_target_speed !== seen_item.target)
            note_mismatch("target_speed", longint'($signed(seen_item.target)),
                          longint'(out_target_speed));
          if (out_motor_command !== seen_item.cmd)
            note_mismatch("motor_command", seen_item.cmd, out_motor_command);
          if (out_engaged !== seen_item.engaged)
            note_mismatch("engaged", seen_item.engaged, out_engaged);
        end
      end
      if (in_valid && in_ready)
        predicted_results.push_back(autopilot_result({in_altitude_mm, in_vertical_speed,
                                                      in_current_power}));
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 6;
    recv_gap_pct = 53;
    @(negedge clk);

    // Out of reset the autopilot is off: hold everywhere, target still shown.
    queue_sample(0, 0, 0);
    queue_sample(ALT_MAX, SPD_MIN, 0);
    queue_sample(300000, SPD_MAX, PWR_MAX);
    wait_idle();

    apply_setting(1, 911, 10000, 1024);
    @(negedge clk);
    // ground: no breakpoint below, target 0, so a zero speed means lower
    queue_sample(0, 0, 0);
    queue_sample(1, SPD_MIN, 0);
    // bottom segment ends at -300 on its breakpoint; speed on target lowers
    queue_sample(400, target_of(400), 500);
    queue_sample(401, target_of(401) - 1, 1023);
    // landing cap: power at the cap holds
    queue_sample(9999, target_of(9999) - 1, 1024);
    // cruise cap from the threshold up
    queue_sample(10000, target_of(10000) - 1, 910);
    queue_sample(10000, target_of(10000) - 1, 911);
    queue_sample(25000, SPD_MAX, PWR_MAX);
    queue_sample(25001, target_of(25001) - 1, 0);
    queue_sample(450000, target_of(450000), 0);
    queue_sample(450001, target_of(450001) - 1, 0);
    queue_sample(1000000, target_of(1000000) + 1, 1024);
    // far above the top breakpoint: extrapolated
    queue_sample(ALT_MAX, SPD_MIN, PWR_MAX);
    queue_sample(ALT_MAX, target_of(ALT_MAX) - 1, 0);
    queue_sample(2097152, -1, 1024);
    queue_sample(1398101, 174762 - 262144, 1365);
    queue_sample(2796202, 87381, 682);
    wait_idle();

    // Random part: one register setting per segment, idling pattern changes
    // every two segments (sender light / receiver heavy, swapped, none).
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_gap_pct = 6;  recv_gap_pct = 53; end
        1: begin send_gap_pct = 53; recv_gap_pct = 6;  end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      case (seg)
        0: apply_setting(1, 911, 10000, 1024);
        1: apply_setting(1, 0, 0, 0);
        2: apply_setting(1, 1024, ALT_MAX, 1024);
        3: apply_setting(0, $urandom_range(1024), $urandom_range(ALT_MAX), $urandom_range(1024));
        4: apply_setting(1, $urandom_range(1024), $urandom_range(300000), $urandom_range(1024));
        default: apply_setting(1, 1024, 200000, 512);
      endcase
      @(negedge clk);
      repeat (SEG_ITEMS) queued_samples.push_back(random_sample());
      wait_idle();
    end

    repeat (12) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dpa_pkg.sv
rtl/descent_profile_autopilot.sv
sim/descent_profile_autopilot_tb.sv
